// ----- rtl/can_frame_serial_framer_assert.svh -----
// Assertion macros for the CAN frame serial framer.
// Included by the port checker; needs nothing else.
`ifndef CAN_FRAME_SERIAL_FRAMER_ASSERT_SVH
`define CAN_FRAME_SERIAL_FRAMER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define CFSF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CFSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cfsf_pkg.sv -----
// Shared types and constants of the CAN frame serial framer.
// No dependencies; imported by every module of the block.
package cfsf_pkg;

   // Default payload limit in bytes
   localparam int MaxPayloadBytesDefault = 8;

   // Frame constants
   localparam logic [7:0] SYNC_BYTE  = 8'hAA;
   localparam logic [3:0] FRAME_TYPE = 4'h8;
   localparam logic [7:0] END_BYTE   = 8'hFF;

   // Register port: byte address width and word index of each register
   localparam int         CsrAddrWidth   = 3;
   localparam logic [0:0] REG_LINK_READY = 1'b0;

   typedef struct packed {
      logic [28:0] can_id;
      logic [3:0]  payload_length;
      logic [63:0] payload;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SYNC1,
      ST_SYNC2,
      ST_HEADER,
      ST_ID0,
      ST_ID1,
      ST_ID2,
      ST_ID3,
      ST_DATA,
      ST_CHECK,
      ST_END
   } state_type;

   typedef enum logic [3:0] {
      SEL_SYNC,
      SEL_HEADER,
      SEL_ID0,
      SEL_ID1,
      SEL_ID2,
      SEL_ID3,
      SEL_DATA,
      SEL_CHECK,
      SEL_END
   } byte_sel_type;

   typedef struct packed {
      logic         load;
      logic         emit;
      byte_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic rem_zero;
      logic rem_one;
   } dp_status_type;

endpackage

// ----- rtl/cfsf_dp.sv -----
// Datapath of the CAN frame serial framer: frame registers, check byte,
// byte select and output register. Uses cfsf_pkg.
module cfsf_dp #(
   parameter int MAX_PAYLOAD_BYTES = cfsf_pkg::MaxPayloadBytesDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfsf_pkg::dp_cmd_type    cmd,
   output cfsf_pkg::dp_status_type status,
   input  cfsf_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output cfsf_pkg::rsp_type       rsp_data
);
   import cfsf_pkg::*;

   localparam int PayWidth = MAX_PAYLOAD_BYTES * 8;
   localparam logic [3:0] MaxLen = 4'(MAX_PAYLOAD_BYTES);

   logic [28:0]         id_ff, id_in;
   logic [3:0]          len_ff, len_in;
   logic [3:0]          rem_ff, rem_in;
   logic [PayWidth-1:0] pay_ff, pay_in;
   logic [7:0]          xor_ff, xor_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_ff, out_in;

   logic [3:0] len_sat;
   logic [7:0] byte_val;
   logic       checked;

   // Clamp the length to the payload limit
   assign len_sat = (req_data.payload_length > MaxLen) ? MaxLen : req_data.payload_length;

   // Select the byte for the current frame position
   always_comb begin
      byte_val = SYNC_BYTE;
      checked  = 1'b0;
      case (cmd.sel)
         SEL_SYNC: begin
            byte_val = SYNC_BYTE;
         end
         SEL_HEADER: begin
            byte_val = {FRAME_TYPE, len_ff};
            checked  = 1'b1;
         end
         SEL_ID0: begin
            byte_val = id_ff[28:21];
            checked  = 1'b1;
         end
         SEL_ID1: begin
            byte_val = {1'b0, id_ff[20:14]};
            checked  = 1'b1;
         end
         SEL_ID2: begin
            byte_val = {1'b0, id_ff[13:7]};
            checked  = 1'b1;
         end
         SEL_ID3: begin
            byte_val = {1'b0, id_ff[6:0]};
            checked  = 1'b1;
         end
         SEL_DATA: begin
            byte_val = pay_ff[7:0];
            checked  = 1'b1;
         end
         SEL_CHECK: begin
            byte_val = xor_ff;
         end
         SEL_END: begin
            byte_val = END_BYTE;
         end
         default: begin
            byte_val = SYNC_BYTE;
         end
      endcase
   end

   // Next values of the frame registers and the output register
   always_comb begin
      id_in        = id_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      pay_in       = pay_ff;
      xor_in       = xor_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      // Capture a new frame and clear the check byte
      if (cmd.load) begin
         id_in  = req_data.can_id;
         len_in = len_sat;
         rem_in = len_sat;
         pay_in = req_data.payload[PayWidth-1:0];
         xor_in = 8'h00;
      end
      // Load the output register, or drop a beat that was taken
      if (cmd.emit) begin
         out_valid_in       = 1'b1;
         out_in.out_byte    = byte_val;
         out_in.frame_end   = (cmd.sel == SEL_END);
         if (checked) begin
            xor_in = xor_ff ^ byte_val;
         end
         if (cmd.sel == SEL_DATA) begin
            pay_in = pay_ff >> 8;
            rem_in = rem_ff - 4'd1;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         xor_ff       <= 8'h00;
         rem_ff       <= 4'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         xor_ff       <= xor_in;
         rem_ff       <= rem_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      len_ff <= len_in;
      pay_ff <= pay_in;
      out_ff <= out_in;
   end

   assign status.out_free = !out_valid_ff || rsp_ready;
   assign status.rem_zero = (rem_ff == 4'd0);
   assign status.rem_one  = (rem_ff == 4'd1);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- rtl/cfsf_ctrl.sv -----
// Controller of the CAN frame serial framer: walks the frame positions
// and issues load and emit commands to the datapath. Uses cfsf_pkg.
module cfsf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    link_ready,
   input  logic                    req_valid,
   output logic                    req_ready,
   output cfsf_pkg::dp_cmd_type    cmd,
   input  cfsf_pkg::dp_status_type status
);
   import cfsf_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.emit  = 1'b0;
      cmd.sel   = SEL_SYNC;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // Take a frame; drop it while the link is closed
            if (req_valid && link_ready) begin
               cmd.load = 1'b1;
               state_in = ST_SYNC1;
            end
         end
         ST_SYNC1: begin
            cmd.sel  = SEL_SYNC;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ST_SYNC2;
         end
         ST_SYNC2: begin
            cmd.sel  = SEL_SYNC;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ST_HEADER;
         end
         ST_HEADER: begin
            cmd.sel  = SEL_HEADER;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ST_ID0;
         end
         ST_ID0: begin
            cmd.sel  = SEL_ID0;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ST_ID1;
         end
         ST_ID1: begin
            cmd.sel  = SEL_ID1;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ST_ID2;
         end
         ST_ID2: begin
            cmd.sel  = SEL_ID2;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ST_ID3;
         end
         ST_ID3: begin
            cmd.sel  = SEL_ID3;
            cmd.emit = status.out_free;
            // Skip the payload of an empty frame
            if (status.out_free) state_in = status.rem_zero ? ST_CHECK : ST_DATA;
         end
         ST_DATA: begin
            cmd.sel  = SEL_DATA;
            cmd.emit = status.out_free;
            if (status.out_free && status.rem_one) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.sel  = SEL_CHECK;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ST_END;
         end
         ST_END: begin
            cmd.sel  = SEL_END;
            cmd.emit = status.out_free;
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/can_frame_serial_framer.sv -----
// CAN frame serial framer, top level: register port, controller, datapath.
// Uses cfsf_pkg, cfsf_ctrl and cfsf_dp.
//
// Usage:
//   req_* takes one extended CAN frame a beat (identifier, length, payload).
//   rsp_* gives the serial frame one byte a beat: AA, AA, header, four
//   identifier bytes, the payload bytes, the check byte and FF, with
//   frame_end set on the FF byte. A length above the payload limit is
//   clamped to it.
//   csr_* holds link_ready at word 0; while it is clear an offered frame is
//   taken and dropped without any output.
// Sequence:
//   A frame is taken in the idle state; the first sync state then loads
//   its first byte into the output register. A frame of n payload bytes
//   gives 9 + n bytes, one byte a cycle while the receiver is ready, out
//   of the controller's position walk. The next frame is taken once the
//   closing byte sits in the output register.
// Reset clears link_ready, the controller state and the output valid flag.
// A stalled receiver holds the current byte and pauses the walk.
module can_frame_serial_framer #(
   parameter int MAX_PAYLOAD_BYTES = cfsf_pkg::MaxPayloadBytesDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cfsf_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cfsf_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cfsf_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import cfsf_pkg::*;

   logic          link_ready_ff, link_ready_in;
   logic          csr_sel_link;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Register port decode
   assign csr_sel_link = (csr_paddr[CsrAddrWidth-1:2] == REG_LINK_READY);

   always_comb begin
      link_ready_in = link_ready_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_sel_link) begin
         link_ready_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ready_ff <= 1'b0;
      end else begin
         link_ready_ff <= link_ready_in;
      end
   end

   assign prdata = csr_sel_link ? {31'b0, link_ready_ff} : 32'b0;
   assign pready = 1'b1;

   cfsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .link_ready (link_ready_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .cmd        (cmd),
      .status     (status)
   );

   cfsf_dp #(
      .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/cfsf_checker.sv -----
// Port checker of the CAN frame serial framer, bound to the top level.
// Uses cfsf_pkg and can_frame_serial_framer_assert.svh.
`include "can_frame_serial_framer_assert.svh"

module cfsf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cfsf_pkg::rsp_type rsp_data
);
   import cfsf_pkg::*;

   // Leave reset idle: no byte pending, frame input open
   `CFSF_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_valid && req_ready), "not idle after reset")

   // Hold a stalled byte
   `CFSF_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)), "stalled byte changed")

   // Set frame_end only on the end byte
   `CFSF_ASSERT(a_end_byte, clock, reset, (rsp_valid && rsp_data.frame_end) |-> (rsp_data.out_byte == END_BYTE), "frame end on wrong byte")

   // Keep the input closed while a frame is still being sent
   `CFSF_ASSERT(a_busy_closed, clock, reset, (rsp_valid && !rsp_data.frame_end) |-> !req_ready, "frame taken mid-frame")

endmodule

bind can_frame_serial_framer cfsf_checker u_checker (.*);
